### rtl/sma_pkg.sv
`timescale 1ns / 1ps

package sma_pkg;

    localparam int unsigned PERIOD_BITS = 9;
    localparam int unsigned SAMPLE_W    = 32;
    localparam int unsigned AVG_W       = 32;
    localparam int unsigned SUM_BITS    = 64;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(20);

    typedef logic [SAMPLE_W-1:0]    sample_t;
    typedef logic [AVG_W-1:0]       avg_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [PERIOD_BITS-1:0] period_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIVGO,
        S_DIV,
        S_OUT
    } sma_state_t;

endpackage

### rtl/sma_if.sv
`timescale 1ns / 1ps

interface sma_in_if;
    import sma_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    logic    start_series;

    modport source (output valid, output sample, output start_series, input ready);
    modport sink   (input valid, input sample, input start_series, output ready);
endinterface

interface sma_out_if;
    import sma_pkg::*;

    logic valid;
    logic ready;
    avg_t average;
    logic valid_res;

    modport source (output valid, output average, output valid_res, input ready);
    modport sink   (input valid, input average, input valid_res, output ready);
endinterface

### rtl/sma_ring.sv
`timescale 1ns / 1ps

module sma_ring #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sma_div.sv
`timescale 1ns / 1ps

module sma_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  sma_pkg::sum_t                 dividend,
    input  sma_pkg::period_t              divisor,
    output logic                          busy,
    output logic                          done,
    output sma_pkg::avg_t                 quotient
);
    import sma_pkg::*;

    localparam int unsigned CNT_W = $clog2(SUM_BITS + 1);

    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    period_t                rem_reg;
    period_t                rem_next;
    sum_t                   q_reg;
    sum_t                   q_next;
    logic [PERIOD_BITS:0]   trial;
    logic                   ge;

    always_comb
    begin
        trial    = {rem_reg, q_reg[SUM_BITS-1]};
        ge       = (trial >= {1'b0, divisor});
        rem_next = ge ? PERIOD_BITS'(trial - {1'b0, divisor}) : PERIOD_BITS'(trial);
        q_next   = {q_reg[SUM_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(SUM_BITS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg[AVG_W-1:0];

endmodule

### rtl/simple_moving_average_top.sv
`timescale 1ns / 1ps

// Boxcar moving average: each sample request yields one result request holding
// the sum of the last period samples divided by period (both capped at MAX_PERIOD,
// truncated) and a flag that is set once period samples of the current series
// were seen; start_series opens a new series. An item with a valid result passes
// these steps in order: the accept with its ring read, one sum update, one divider
// start, the divider run (through every bit of the 64-bit running sum, then a done
// pulse) and one output load, which waits while the previous result is not taken.
// During warm-up or with period 0 the divider is skipped. The block takes one item
// at a time; a finished result waits in an output register while the next sample
// is accepted. Write period only while the block is idle.
module simple_moving_average_top #(
    parameter int unsigned MAX_PERIOD  = 256,
    parameter int unsigned SAMPLE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    sma_in_if.sink                       din,
    sma_out_if.source                    dout,
    input  logic                         cfg_we,
    input  logic [sma_pkg::PERIOD_BITS-1:0] cfg_wdata
);
    import sma_pkg::*;

    localparam int unsigned RING_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int unsigned PTR_W  = $clog2(MAX_PERIOD);
    localparam int unsigned IDX_W  = $clog2(2 * MAX_PERIOD);
    localparam int unsigned SEEN_W = $clog2(MAX_PERIOD + 1);
    localparam int unsigned CMP_W  = (SEEN_W > PERIOD_BITS) ? SEEN_W : PERIOD_BITS;

    sma_state_t           state_reg;
    sma_state_t           state_next;
    period_t              period_reg;
    period_t              eff_p;
    period_t              p_reg;
    logic [PTR_W-1:0]     ptr_reg;
    logic [SEEN_W-1:0]    seen_reg;
    logic [SEEN_W-1:0]    seen_inc;
    sum_t                 sum_reg;
    sum_t                 sum_upd;
    logic [RING_W-1:0]    x_reg;
    logic [RING_W-1:0]    ring_rd;
    logic [IDX_W-1:0]     idx_raw;
    logic [PTR_W-1:0]     rd_addr;
    logic                 sub_old;
    logic                 ok_new;
    logic                 ok_reg;
    avg_t                 avg_reg;
    avg_t                 out_avg_reg;
    logic                 out_ok_reg;
    logic                 out_valid_reg;
    logic                 in_acc;
    logic                 ring_we;
    logic                 div_start;
    logic                 div_busy;
    logic                 div_done;
    avg_t                 div_q;
    logic                 out_load;

    always_comb
    begin
        if (32'(period_reg) > MAX_PERIOD)
        begin
            eff_p = PERIOD_BITS'(MAX_PERIOD);
        end
        else
        begin
            eff_p = period_reg;
        end
        idx_raw = IDX_W'(ptr_reg) + IDX_W'(MAX_PERIOD) - IDX_W'(eff_p);
        if (idx_raw >= IDX_W'(MAX_PERIOD))
        begin
            idx_raw = idx_raw - IDX_W'(MAX_PERIOD);
        end
        rd_addr = idx_raw[PTR_W-1:0];

        sub_old  = (p_reg != '0) && (CMP_W'(seen_reg) >= CMP_W'(p_reg));
        seen_inc = (32'(seen_reg) < MAX_PERIOD) ? seen_reg + SEEN_W'(1) : seen_reg;
        ok_new   = (p_reg != '0) && (CMP_W'(seen_inc) >= CMP_W'(p_reg));
        sum_upd  = sum_reg + SUM_BITS'(x_reg)
                   - (sub_old ? SUM_BITS'(ring_rd) : SUM_BITS'(0));
    end

    assign in_acc   = din.valid && din.ready;
    assign din.ready = (state_reg == S_IDLE);
    assign ring_we  = (state_reg == S_SUM);
    assign div_start = (state_reg == S_DIVGO);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || dout.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = ok_new ? S_DIVGO : S_OUT;
            end
            S_DIVGO:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            ptr_reg       <= '0;
            seen_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
            if (in_acc && din.start_series)
            begin
                seen_reg <= '0;
                sum_reg  <= '0;
            end
            if (state_reg == S_SUM)
            begin
                if (p_reg != '0)
                begin
                    sum_reg <= sum_upd;
                end
                seen_reg <= seen_inc;
                if (ptr_reg == PTR_W'(MAX_PERIOD - 1))
                begin
                    ptr_reg <= '0;
                end
                else
                begin
                    ptr_reg <= ptr_reg + PTR_W'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg <= din.sample[RING_W-1:0];
            p_reg <= eff_p;
        end
        if (state_reg == S_SUM)
        begin
            ok_reg  <= ok_new;
            avg_reg <= '0;
        end
        if (div_done)
        begin
            avg_reg <= div_q;
        end
        if (out_load)
        begin
            out_avg_reg <= avg_reg;
            out_ok_reg  <= ok_reg;
        end
    end

    assign dout.valid     = out_valid_reg;
    assign dout.average   = out_avg_reg;
    assign dout.valid_res = out_ok_reg;

    sma_ring #(
        .DEPTH (MAX_PERIOD),
        .WIDTH (RING_W),
        .AW    (PTR_W)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ptr_reg),
        .wdata (x_reg),
        .re    (in_acc),
        .raddr (rd_addr),
        .rdata (ring_rd)
    );

    sma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (p_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

`ifndef SYNTHESIS
    a_no_accept_while_div: assert property (@(posedge clk) disable iff (!rst_n)
        din.ready |-> !div_busy)
        else $error("sample request accepted while divider busy");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> !din.ready)
        else $error("second sample request accepted during processing");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(seen_reg) <= MAX_PERIOD)
        else $error("sample count beyond window depth");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && !dout.valid_res) |-> (dout.average == '0))
        else $error("nonzero average on invalid result");
`endif

endmodule
